// ===== rtl/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int CMD_W  = 2;
    localparam int BYTE_W = 8;
    localparam int POS_W  = 11;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-1:0] ADDR_TEXT_ATTR = 3'd0;

    localparam logic [BYTE_W-1:0] ATTR_RESET = 8'h07;
    localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
    localparam logic [BYTE_W-1:0] LF_CHAR    = 8'd10;
    localparam logic [BYTE_W-1:0] CR_CHAR    = 8'd13;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_BS    = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic              char_we;
        logic              attr_we;
        logic [BYTE_W-1:0] char_data;
        logic [BYTE_W-1:0] attr_data;
    } store_wr_t;

endpackage

// ===== rtl/tcw_if.sv =====
// Command and result channel interfaces of the text console writer.
interface tcw_req_if import tcw_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] char_code;
    logic [POS_W-1:0]  cell_index;

    modport source (output valid, output command, output char_code, output cell_index,
                    input ready);
    modport sink (input valid, input command, input char_code, input cell_index,
                  output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*;;
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  cursor_pos;
    logic [BYTE_W-1:0] read_char;
    logic [BYTE_W-1:0] read_attr;

    modport source (output valid, output cursor_pos, output read_char, output read_attr,
                    input ready);
    modport sink (input valid, input cursor_pos, input read_char, input read_attr,
                  output ready);
endinterface

// ===== rtl/tcw_store.sv =====
// Character and attribute cell memories with registered read data.
module tcw_store import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS = DEF_ROWS,
    localparam int CELLS = COLUMNS * ROWS,
    localparam int AW = $clog2(CELLS)
)
(
    input  logic              clk,
    input  store_wr_t         wr,
    input  logic [AW-1:0]     waddr,
    input  logic              rd_en,
    input  logic [AW-1:0]     raddr,
    output logic [BYTE_W-1:0] rd_char,
    output logic [BYTE_W-1:0] rd_attr
);

    logic [BYTE_W-1:0] char_mem [CELLS];
    logic [BYTE_W-1:0] attr_mem [CELLS];

    always_ff @(posedge clk)
    begin
        if (wr.char_we)
        begin
            char_mem[waddr] <= wr.char_data;
        end
        if (rd_en)
        begin
            rd_char <= char_mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.attr_we)
        begin
            attr_mem[waddr] <= wr.attr_data;
        end
        if (rd_en)
        begin
            rd_attr <= attr_mem[raddr];
        end
    end

endmodule

// ===== rtl/tcw_seq.sv =====
// Sequencer: cursor, cell sweep counter for fill and scroll, result register.
module tcw_seq import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS = DEF_ROWS,
    localparam int CELLS = COLUMNS * ROWS,
    localparam int AW = $clog2(CELLS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    tcw_req_if.sink           req,
    tcw_rsp_if.source         rsp,
    input  logic [BYTE_W-1:0] text_attr,
    output store_wr_t         wr,
    output logic [AW-1:0]     waddr,
    output logic              rd_en,
    output logic [AW-1:0]     raddr,
    input  logic [BYTE_W-1:0] rd_char,
    input  logic [BYTE_W-1:0] rd_attr
);

    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);
    localparam int WW = ((AW > POS_W) ? AW : POS_W) + 1;

    localparam logic [CW-1:0] COL_MAX   = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_MAX   = RW'(ROWS - 1);
    localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
    localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);

    typedef enum logic [6:0] {
        ST_INIT       = 7'b0000001,
        ST_IDLE       = 7'b0000010,
        ST_CLEAR      = 7'b0000100,
        ST_SCROLL_PRE = 7'b0001000,
        ST_SCROLL     = 7'b0010000,
        ST_DONE       = 7'b0100000,
        ST_SPARE      = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [BYTE_W-1:0] fill_attr_reg, fill_attr_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [AW-1:0]     row_base_reg, row_base_next;
    logic              hit_reg, hit_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] rchar_reg, rchar_next;
    logic [BYTE_W-1:0] rattr_reg, rattr_next;

    logic          accept;
    logic          new_line;
    logic [AW-1:0] cur_addr;
    logic [WW-1:0] cur_wide;
    logic [WW-1:0] cell_wide;
    logic [WW-1:0] src_wide;

    assign req.ready      = (state_reg == ST_IDLE);
    assign accept         = req.valid && req.ready;
    assign cur_addr       = AW'(row_base_reg + AW'(col_reg));
    assign cur_wide       = WW'(cur_addr);
    assign cell_wide      = WW'(req.cell_index);
    assign src_wide       = WW'(idx_reg) + WW'(COLUMNS + 1);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.cursor_pos = pos_reg;
    assign rsp.read_char  = rchar_reg;
    assign rsp.read_attr  = rattr_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        fill_attr_next = fill_attr_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        row_base_next  = row_base_reg;
        hit_next       = hit_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        pos_next       = pos_reg;
        rchar_next     = rchar_reg;
        rattr_next     = rattr_reg;
        wr             = '0;
        waddr          = cur_addr;
        rd_en          = 1'b0;
        raddr          = '0;
        new_line       = 1'b0;

        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                wr.char_we   = 1'b1;
                wr.attr_we   = 1'b1;
                wr.char_data = SPACE_CHAR;
                wr.attr_data = fill_attr_reg;
                waddr        = idx_reg;
                if (idx_reg == CELL_LAST)
                begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
                else
                begin
                    idx_next = AW'(idx_reg + AW'(1));
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    hit_next   = 1'b0;
                    state_next = ST_DONE;
                    unique case (cmd_t'(req.command))
                        CMD_PUT:
                        begin
                            if (req.char_code == LF_CHAR || req.char_code == CR_CHAR)
                            begin
                                new_line = 1'b1;
                            end
                            else
                            begin
                                wr.char_we   = 1'b1;
                                wr.attr_we   = 1'b1;
                                wr.char_data = req.char_code;
                                wr.attr_data = text_attr;
                                if (col_reg == COL_MAX)
                                begin
                                    new_line = 1'b1;
                                end
                                else
                                begin
                                    col_next = CW'(col_reg + CW'(1));
                                end
                            end
                            if (new_line)
                            begin
                                col_next = '0;
                                if (row_reg != ROW_MAX)
                                begin
                                    row_next      = RW'(row_reg + RW'(1));
                                    row_base_next = AW'(row_base_reg + ROW_STEP);
                                end
                                else
                                begin
                                    state_next = ST_SCROLL_PRE;
                                end
                            end
                        end
                        CMD_BS:
                        begin
                            if (col_reg != '0 || row_reg != '0)
                            begin
                                wr.char_we   = 1'b1;
                                wr.attr_we   = 1'b1;
                                wr.char_data = SPACE_CHAR;
                                wr.attr_data = text_attr;
                                waddr        = AW'(cur_addr - AW'(1));
                                if (col_reg == '0)
                                begin
                                    col_next      = COL_MAX;
                                    row_next      = RW'(row_reg - RW'(1));
                                    row_base_next = AW'(row_base_reg - ROW_STEP);
                                end
                                else
                                begin
                                    col_next = CW'(col_reg - CW'(1));
                                end
                            end
                        end
                        CMD_CLEAR:
                        begin
                            fill_attr_next = text_attr;
                            idx_next       = '0;
                            col_next       = '0;
                            row_next       = '0;
                            row_base_next  = '0;
                            state_next     = ST_CLEAR;
                        end
                        CMD_READ:
                        begin
                            if (cell_wide < WW'(CELLS))
                            begin
                                rd_en    = 1'b1;
                                raddr    = cell_wide[AW-1:0];
                                hit_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCROLL_PRE:
            begin
                rd_en      = 1'b1;
                raddr      = ROW_STEP;
                idx_next   = '0;
                state_next = ST_SCROLL;
            end
            ST_SCROLL:
            begin
                wr.char_we   = 1'b1;
                wr.char_data = (WW'(idx_reg) < WW'(CELLS - COLUMNS)) ? rd_char : SPACE_CHAR;
                waddr        = idx_reg;
                if (src_wide < WW'(CELLS))
                begin
                    rd_en = 1'b1;
                    raddr = src_wide[AW-1:0];
                end
                if (idx_reg == CELL_LAST)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = AW'(idx_reg + AW'(1));
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    pos_next       = cur_wide[POS_W-1:0];
                    rchar_next     = hit_reg ? rd_char : '0;
                    rattr_next     = hit_reg ? rd_attr : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            idx_reg       <= '0;
            fill_attr_reg <= ATTR_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            row_base_reg  <= '0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            fill_attr_reg <= fill_attr_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            row_base_reg  <= row_base_next;
            hit_reg       <= hit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        rchar_reg <= rchar_next;
        rattr_reg <= rattr_next;
    end

endmodule

// ===== rtl/text_console_writer_top.sv =====
// Top level of the text console writer: register port, sequencer and cell store.
//
// Commands arrive as beats on req (valid/ready) and each one yields exactly one
// result beat on rsp, carrying the cursor position after the command and, for a
// read, the addressed cell. The block takes one command at a time; req.ready is
// high only while the sequencer is idle.
// A put that does not scroll, a backspace or a read goes to the done state,
// which registers its result once the output register is free, then to idle.
// Clear sweeps the cell store one cell per cycle; a new line on the last row
// scrolls, which streams the character cells through the single read port and
// write port of the memory, leaving the attributes where they are.
// The result sits in an output register; a new command is accepted while it
// waits, and a stalled receiver holds back the next result and further commands.
// After reset the block runs a clearing pass that fills every cell with a space
// and attribute 7; no command is accepted meanwhile, but register writes are
// taken. The text attribute resets to 7.
// The attribute register lies at byte address 0 of the APB port.
module text_console_writer_top import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS = DEF_ROWS
)
(
    input  logic               clk,
    input  logic               rst_n,
    tcw_req_if.sink            req,
    tcw_rsp_if.source          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int AW = $clog2(COLUMNS * ROWS);

    logic [BYTE_W-1:0] text_attr_reg, text_attr_next;
    store_wr_t         wr;
    logic [AW-1:0]     waddr;
    logic              rd_en;
    logic [AW-1:0]     raddr;
    logic [BYTE_W-1:0] rd_char;
    logic [BYTE_W-1:0] rd_attr;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TEXT_ATTR) ? PDATA_W'(text_attr_reg) : '0;

    always_comb
    begin
        text_attr_next = text_attr_reg;
        if (psel && penable && pwrite && pready && paddr == ADDR_TEXT_ATTR)
        begin
            text_attr_next = pwdata[BYTE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_attr_reg <= ATTR_RESET;
        end
        else
        begin
            text_attr_reg <= text_attr_next;
        end
    end

    tcw_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .text_attr (text_attr_reg),
        .wr        (wr),
        .waddr     (waddr),
        .rd_en     (rd_en),
        .raddr     (raddr),
        .rd_char   (rd_char),
        .rd_attr   (rd_attr)
    );

    tcw_store #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_store (
        .clk     (clk),
        .wr      (wr),
        .waddr   (waddr),
        .rd_en   (rd_en),
        .raddr   (raddr),
        .rd_char (rd_char),
        .rd_attr (rd_attr)
    );

endmodule

// ===== test/tb_checker.sv =====
// Console predictor and result checker for the text console writer testbench.
`timescale 1ns / 100ps

module tb_checker
    import tcw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    tcw_req_if                 req,
    tcw_rsp_if                 rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 fail_count,
    output int                 pending,
    output int                 result_count,
    output int                 scroll_count
);

    localparam int NCOLS  = DEF_COLUMNS;
    localparam int NROWS  = DEF_ROWS;
    localparam int NCELLS = NCOLS * NROWS;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] ch;
        logic [BYTE_W-1:0] attr;
    } console_result_t;

    logic [BYTE_W-1:0] char_mem [NCELLS];
    logic [BYTE_W-1:0] attr_mem [NCELLS];
    logic [BYTE_W-1:0] text_attr;
    int                cur_col;
    int                cur_row;
    console_result_t   result_q [$];

    function automatic void wipe_console(input logic [BYTE_W-1:0] attr);
        for (int i = 0; i < NCELLS; i++)
        begin
            char_mem[i] = SPACE_CHAR;
            attr_mem[i] = attr;
        end
        cur_col = 0;
        cur_row = 0;
    endfunction

    // Only characters move up; attributes stay where they are.
    function automatic void scroll_text();
        for (int i = 0; i + NCOLS < NCELLS; i++)
        begin
            char_mem[i] = char_mem[i + NCOLS];
        end
        for (int i = NCELLS - NCOLS; i < NCELLS; i++)
        begin
            char_mem[i] = SPACE_CHAR;
        end
        cur_col = 0;
        scroll_count++;
    endfunction

    function automatic void line_feed();
        if (cur_row + 1 < NROWS)
        begin
            cur_col = 0;
            cur_row++;
        end
        else
        begin
            scroll_text();
        end
    endfunction

    function automatic void write_char(input logic [BYTE_W-1:0] c);
        int p;
        if (c == LF_CHAR || c == CR_CHAR)
        begin
            line_feed();
            return;
        end
        p = cur_row * NCOLS + cur_col;
        char_mem[p] = c;
        attr_mem[p] = text_attr;
        if (cur_col + 1 >= NCOLS)
        begin
            line_feed();
        end
        else
        begin
            cur_col++;
        end
    endfunction

    function automatic void erase_back();
        int p;
        if (cur_col == 0 && cur_row == 0)
        begin
            return;
        end
        p = cur_row * NCOLS + cur_col - 1;
        char_mem[p] = SPACE_CHAR;
        attr_mem[p] = text_attr;
        if (cur_col == 0)
        begin
            cur_col = NCOLS - 1;
            cur_row--;
        end
        else
        begin
            cur_col--;
        end
    endfunction

    function automatic console_result_t apply_command(input cmd_t cmd,
                                                      input logic [BYTE_W-1:0] code,
                                                      input logic [POS_W-1:0] cell_idx);
        console_result_t r;
        r.ch   = '0;
        r.attr = '0;
        case (cmd)
            CMD_PUT:   write_char(code);
            CMD_BS:    erase_back();
            CMD_CLEAR: wipe_console(text_attr);
            default:
            begin
                if (int'(cell_idx) < NCELLS)
                begin
                    r.ch   = char_mem[cell_idx];
                    r.attr = attr_mem[cell_idx];
                end
            end
        endcase
        r.pos = POS_W'(cur_row * NCOLS + cur_col);
        return r;
    endfunction

    always @(posedge clk)
    begin
        console_result_t want;
        if (!rst_n)
        begin
            text_attr    = ATTR_RESET;
            wipe_console(ATTR_RESET);
            result_q.delete();
            fail_count   = 0;
            result_count = 0;
            scroll_count = 0;
            pending      = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (result_q.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("Unexpected beat: cursor_pos %0d read_char %02h read_attr %02h",
                                 rsp.cursor_pos, rsp.read_char, rsp.read_attr);
                    end
                    fail_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (rsp.cursor_pos !== want.pos || rsp.read_char !== want.ch ||
                        rsp.read_attr !== want.attr)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("Mismatch on result %0d: cursor_pos exp %0d got %0d,",
                                     result_count, want.pos, rsp.cursor_pos);
                            $display("    read_char exp %02h got %02h, read_attr exp %02h got %02h",
                                     want.ch, rsp.read_char, want.attr, rsp.read_attr);
                        end
                        fail_count++;
                    end
                    result_count++;
                end
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_TEXT_ATTR)
            begin
                text_attr = pwdata[BYTE_W-1:0];
            end
            if (req.valid && req.ready)
            begin
                result_q.push_back(apply_command(cmd_t'(req.command), req.char_code,
                                                 req.cell_index));
            end
            pending = result_q.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// Top of the text console writer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
    import tcw_pkg::*;

    localparam int LIMIT = 3_000_000;
    localparam int RANDOM_PER_PHASE = 75;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int pending;
    int result_count;
    int scroll_count;
    int cycle_count = 0;
    int dispatched = 0;
    int directed_count = 0;
    int attr_writes = 0;
    bit calm = 1'b0;

    tcw_req_if req ();
    tcw_rsp_if rsp ();

    text_console_writer_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tb_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rsp          (rsp),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count),
        .scroll_count (scroll_count)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
            $display("tb NOT OK");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rsp.ready <= calm || ($urandom_range(99) >= 31);
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic issue_command(input cmd_t cmd, input logic [BYTE_W-1:0] code,
                                 input logic [POS_W-1:0] cell_idx);
        while (!calm && $urandom_range(99) < 31)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid      <= 1'b1;
        req.command    <= cmd;
        req.char_code  <= code;
        req.cell_index <= cell_idx;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        dispatched++;
    endtask

    task automatic drain_results();
        req.valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending != 0);
    endtask

    task automatic write_attr(input logic [BYTE_W-1:0] attr);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TEXT_ATTR;
        pwdata  <= {{(PDATA_W-BYTE_W){1'b0}}, attr};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        attr_writes++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_char();
        if ($urandom_range(99) < 80)
        begin
            return BYTE_W'($urandom_range(8'h7e, 8'h20));
        end
        return BYTE_W'($urandom_range(255));
    endfunction

    function automatic logic [POS_W-1:0] pick_cell();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
        begin
            return POS_W'($urandom_range(1999));
        end
        else if (roll < 80)
        begin
            return POS_W'($urandom_range(2047, 2000));
        end
        return POS_W'($urandom_range(2047));
    endfunction

    function automatic int run_length(input int short_max, input int long_min,
                                      input int long_max);
        if ($urandom_range(99) < 15)
        begin
            return $urandom_range(long_max, long_min);
        end
        return $urandom_range(short_max, 1);
    endfunction

    function automatic int cap_run(input int n, input int left);
        return (n < left) ? n : left;
    endfunction

    task automatic random_traffic(input int quota);
        int stop_at;
        int roll;
        int n;
        stop_at = dispatched + quota;
        while (dispatched < stop_at)
        begin
            roll = $urandom_range(99);
            if (roll < 35)
            begin
                n = cap_run(run_length(20, 60, 100), stop_at - dispatched);
                repeat (n) issue_command(CMD_PUT, pick_char(), POS_W'($urandom_range(2047)));
            end
            else if (roll < 50)
            begin
                n = cap_run(run_length(6, 24, 30), stop_at - dispatched);
                repeat (n)
                begin
                    issue_command(CMD_PUT, $urandom_range(1) ? LF_CHAR : CR_CHAR,
                                  POS_W'($urandom_range(2047)));
                end
            end
            else if (roll < 65)
            begin
                n = cap_run(run_length(10, 80, 100), stop_at - dispatched);
                repeat (n) issue_command(CMD_BS, BYTE_W'($urandom_range(255)),
                                         POS_W'($urandom_range(2047)));
            end
            else if (roll < 85)
            begin
                n = cap_run($urandom_range(5, 1), stop_at - dispatched);
                repeat (n) issue_command(CMD_READ, BYTE_W'($urandom_range(255)), pick_cell());
            end
            else if (roll < 88)
            begin
                issue_command(CMD_CLEAR, BYTE_W'($urandom_range(255)),
                              POS_W'($urandom_range(2047)));
            end
            else
            begin
                n = cap_run($urandom_range(3, 1), stop_at - dispatched);
                repeat (n)
                begin
                    issue_command(cmd_t'($urandom_range(3)), BYTE_W'($urandom_range(255)),
                                  POS_W'($urandom_range(2047)));
                end
            end
        end
    endtask

    initial
    begin
        req.valid      = 1'b0;
        req.command    = CMD_PUT;
        req.char_code  = '0;
        req.cell_index = '0;
        rsp.ready      = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset contents, out-of-range reads and backspace at home.
        issue_command(CMD_READ, 8'h00, 11'd0);
        issue_command(CMD_READ, 8'hff, 11'd1999);
        issue_command(CMD_READ, 8'h00, 11'd2000);
        issue_command(CMD_READ, 8'h00, 11'd2047);
        issue_command(CMD_BS, 8'h00, 11'd0);
        issue_command(CMD_PUT, 8'h41, 11'd0);
        issue_command(CMD_PUT, 8'h00, 11'd0);
        issue_command(CMD_PUT, 8'hff, 11'd2047);
        issue_command(CMD_READ, 8'h00, 11'd1);
        issue_command(CMD_READ, 8'h00, 11'd2);
        write_attr(8'hff);
        issue_command(CMD_PUT, 8'h5a, 11'd0);
        issue_command(CMD_PUT, LF_CHAR, 11'd0);
        issue_command(CMD_BS, 8'h00, 11'd0);
        issue_command(CMD_READ, 8'h00, 11'd79);
        issue_command(CMD_PUT, CR_CHAR, 11'd0);
        issue_command(CMD_CLEAR, 8'h00, 11'd0);
        issue_command(CMD_READ, 8'h00, 11'd0);
        issue_command(CMD_READ, 8'h00, 11'd1999);
        issue_command(CMD_BS, 8'hff, 11'd2047);
        write_attr(8'h00);
        issue_command(CMD_PUT, 8'h78, 11'd0);
        issue_command(CMD_READ, 8'h00, 11'd0);
        directed_count = dispatched;

        write_attr(BYTE_W'($urandom_range(255)));
        random_traffic(RANDOM_PER_PHASE);
        write_attr(ATTR_RESET);
        calm = 1'b1;
        random_traffic(RANDOM_PER_PHASE);
        calm = 1'b0;
        write_attr(8'hff);
        random_traffic(RANDOM_PER_PHASE);
        write_attr(BYTE_W'($urandom_range(255)));
        random_traffic(RANDOM_PER_PHASE);

        drain_results();
        repeat (50) @(posedge clk);
        $display("Covered %0d commands (%0d directed) under %0d attribute writes.",
                 dispatched, directed_count, attr_writes);
        $display("Checked %0d result beats, including %0d scrolls.", result_count, scroll_count);
        if (fail_count == 0 && pending == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
